>>> hdl/lrsf_pkg.sv
// ----------------------------------------------------------------------------
// Line run span finder package
// Shared constants: register indexes, field widths and reset values.
// ----------------------------------------------------------------------------
package lrsf_pkg;

    localparam int LINE_MAX_DEF = 256;

    localparam int VOXEL_W   = 8;
    localparam int THRESH_W  = 8;
    localparam int RUN_W     = 9;
    localparam int DIL_W     = 9;
    localparam int START_W   = 9;
    localparam int END_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 9;
    localparam int S_DATA_W  = 8;
    localparam int M_DATA_W  = 24;

    localparam logic [CFG_IDX_W-1:0] REG_HIT_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DILATION      = 2'd2;

    localparam logic [THRESH_W-1:0] THRESH_RESET  = 8'd20;
    localparam logic [RUN_W-1:0]    MIN_RUN_RESET = 9'd2;
    localparam logic [DIL_W-1:0]    DIL_RESET     = 9'd0;

endpackage

>>> hdl/lrsf_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module lrsf_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/line_run_span_finder_top.sv
// ----------------------------------------------------------------------------
// Line run span finder
// Finds the filled span of one voxel line from runs of above-threshold hits.
// ----------------------------------------------------------------------------
// Voxels of a line arrive one per beat on the slave stream, the final voxel
// flagged by s_tlast. Each voxel is a hit when it is strictly above
// hit_threshold; its hit bit goes into a one-bit-wide RAM of LINE_MAX
// entries while a forward run counter looks for the first run of min_run
// hits, which sets the span start just past that run. After the closing beat
// the block stops taking beats and walks the stored hits backward from the
// line end, one RAM read per cycle, looking for the first run of min_run
// hits above the start; the span end is the index just before it, or the
// start when no run is met (the last index if the start lies past it). Both
// ends are then widened by dilation and clamped to the line. After the
// closing beat the slave stream is held off through ST_PREP, the backward
// scan in ST_SCAN (at most the line length minus one steps, set by the
// single read port of the hit RAM) and ST_FIN; a line with no forward run
// goes from ST_PREP straight to ST_FIN. The result goes into an
// output register, so the next line loads while the result waits; only the
// next line end stalls if the previous result has not been taken. Voxels
// past LINE_MAX are dropped, though s_tlast still closes the line. When no
// forward run is found the result beat carries span_found = 0 and zeros.
// Configuration writes are taken at any time but belong between lines.
module line_run_span_finder_top #(
    parameter int LINE_MAX = lrsf_pkg::LINE_MAX_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write port
    input  logic                              cfg_we,
    input  logic [lrsf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lrsf_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Voxel stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lrsf_pkg::S_DATA_W-1:0]     s_tdata,   // [7:0] voxel
    input  logic                              s_tlast,   // last_in_line
    // Span result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lrsf_pkg::M_DATA_W-1:0]     m_tdata,   // [8:0] span_start, [16:9] span_end
    output logic                              m_tuser    // span_found
);

    import lrsf_pkg::*;

    // Position counter must hold LINE_MAX itself; RAM addresses do not.
    localparam int AW = $clog2(LINE_MAX);
    localparam int PW = $clog2(LINE_MAX + 1);
    // Width for the dilation arithmetic, one bit of headroom.
    localparam int XW = ((PW > DIL_W) ? PW : DIL_W) + 1;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_PREP,
        ST_SCAN,
        ST_FIN
    } state_t;

    state_t           state_reg;

    logic [THRESH_W-1:0] thresh_reg;
    logic [RUN_W-1:0]    min_run_reg;
    logic [DIL_W-1:0]    dil_reg;

    // Forward scan state of the line being loaded.
    logic [PW-1:0]    pos_reg;
    logic [RUN_W-1:0] frun_reg;
    logic [PW-1:0]    fedge_reg;
    logic             efound_reg;

    // Backward scan state.
    logic [AW-1:0]    c_reg;
    logic [RUN_W-1:0] brun_reg;
    logic [PW-1:0]    start_reg;
    logic [AW-1:0]    end_reg;
    logic             found_reg;

    // Result register.
    logic             out_valid_reg;
    logic             out_found_reg;
    logic [START_W-1:0] out_start_reg;
    logic [END_W-1:0]   out_end_reg;

    logic             accept;
    logic             store_en;
    logic             hit;
    logic [RUN_W-1:0] frun_next;
    logic             ram_rdata;
    logic [AW-1:0]    ram_raddr;
    logic [PW-1:0]    pos_m1;
    logic             scan_more;
    logic             out_free;
    logic [XW-1:0]    start_x;
    logic [XW-1:0]    end_x;
    logic [XW-1:0]    dil_x;
    logic [XW-1:0]    lastidx_x;
    logic [XW-1:0]    dstart_x;
    logic [XW-1:0]    dend_x;

    assign s_tready = (state_reg == ST_LOAD);
    assign accept   = s_tvalid && s_tready;
    assign store_en = accept && (pos_reg < PW'(LINE_MAX));
    assign hit      = (s_tdata[VOXEL_W-1:0] > thresh_reg);
    assign frun_next = hit ? (frun_reg + RUN_W'(1)) : '0;

    assign pos_m1    = pos_reg - PW'(1);
    assign ram_raddr = (state_reg == ST_PREP) ? pos_m1[AW-1:0] : (c_reg - AW'(1));

    // The RAM output holds the hit bit of c_reg while scanning.
    assign scan_more = (PW'(c_reg) > start_reg) && (brun_reg < min_run_reg);

    assign out_free  = !out_valid_reg || m_tready;

    assign start_x   = XW'(start_reg);
    assign end_x     = XW'(end_reg);
    assign dil_x     = XW'(dil_reg);
    assign lastidx_x = XW'(pos_m1);
    assign dstart_x  = (start_x >= dil_x) ? (start_x - dil_x) : '0;
    assign dend_x    = ((end_x + dil_x) <= lastidx_x) ? (end_x + dil_x) : lastidx_x;

    lrsf_ram #(
        .WIDTH (1),
        .DEPTH (LINE_MAX)
    ) u_hit_ram (
        .clk   (clk),
        .we    (store_en),
        .waddr (pos_reg[AW-1:0]),
        .wdata (hit),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg  <= THRESH_RESET;
            min_run_reg <= MIN_RUN_RESET;
            dil_reg     <= DIL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HIT_THRESHOLD: thresh_reg  <= cfg_data[THRESH_W-1:0];
                REG_MIN_RUN:       min_run_reg <= cfg_data[RUN_W-1:0];
                REG_DILATION:      dil_reg     <= cfg_data[DIL_W-1:0];
                default:           ;
            endcase
        end
    end

    // Sequencer: state and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            pos_reg       <= '0;
            frun_reg      <= '0;
            fedge_reg     <= '0;
            efound_reg    <= 1'b0;
            c_reg         <= '0;
            brun_reg      <= '0;
            start_reg     <= '0;
            end_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_found_reg <= 1'b0;
            out_start_reg <= '0;
            out_end_reg   <= '0;
        end
        else
        begin
            // In ST_FIN the result register is handled by the state itself.
            if (out_valid_reg && m_tready && (state_reg != ST_FIN))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_LOAD:
                begin
                    if (accept)
                    begin
                        if (store_en)
                        begin
                            pos_reg <= pos_reg + PW'(1);
                            if (!efound_reg && (min_run_reg != '0))
                            begin
                                frun_reg <= frun_next;
                                if (frun_next >= min_run_reg)
                                begin
                                    efound_reg <= 1'b1;
                                    fedge_reg  <= pos_reg + PW'(1);
                                end
                            end
                        end
                        if (s_tlast)
                        begin
                            state_reg <= ST_PREP;
                        end
                    end
                end

                ST_PREP:
                begin
                    // A zero run length counts as found at index 0.
                    brun_reg <= '0;
                    c_reg    <= pos_m1[AW-1:0];
                    if (min_run_reg == '0)
                    begin
                        found_reg <= 1'b1;
                        start_reg <= '0;
                        state_reg <= ST_SCAN;
                    end
                    else if (efound_reg)
                    begin
                        found_reg <= 1'b1;
                        start_reg <= fedge_reg;
                        state_reg <= ST_SCAN;
                    end
                    else
                    begin
                        found_reg <= 1'b0;
                        start_reg <= '0;
                        end_reg   <= '0;
                        state_reg <= ST_FIN;
                    end
                end

                ST_SCAN:
                begin
                    if (scan_more)
                    begin
                        brun_reg <= ram_rdata ? (brun_reg + RUN_W'(1)) : '0;
                        c_reg    <= c_reg - AW'(1);
                    end
                    else
                    begin
                        end_reg   <= c_reg;
                        state_reg <= ST_FIN;
                    end
                end

                ST_FIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_found_reg <= found_reg;
                        out_start_reg <= found_reg ? START_W'(dstart_x) : '0;
                        out_end_reg   <= found_reg ? END_W'(dend_x) : '0;
                        pos_reg       <= '0;
                        frun_reg      <= '0;
                        fedge_reg     <= '0;
                        efound_reg    <= 1'b0;
                        state_reg     <= ST_LOAD;
                    end
                end

                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = {{(M_DATA_W - START_W - END_W){1'b0}}, out_end_reg, out_start_reg};

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line run span finder testbench
// Streams voxel lines into the span finder under random pacing on both
// streams, predicts each line's span and compares every result beat.
// ----------------------------------------------------------------------------
// Overview
//   A short table of directed lines comes first. It covers reset values,
//   field extremes, the unknown register index, masking of wide register
//   data, a zero run length, lines longer than the hit store and runs that
//   close at the line end. Where a row's result is obvious it carries the
//   expected span. Every other row, and all of the random lines that follow,
//   is checked against the span predictor kept in this file.
//
//   Monitors sample at the rising edge and the drivers change inputs at the
//   falling edge, so nothing depends on event order within a time step.
//   Register writes are only issued once every expected span has come back
//   and the block has had a few cycles to settle.
// ----------------------------------------------------------------------------
module tb;

    import lrsf_pkg::*;

    localparam int LINE_MAX = LINE_MAX_DEF;

    // Index that maps to no register; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT      = 1_000_000;
    // The backward scan walks at most one line of stored hits.
    localparam int DRAIN_CYCLES     = LINE_MAX + 16;
    // Voxel beats over the whole run, directed lines included.
    localparam int TOTAL_BEATS      = 1600;

    // One span result as the block reports it.
    typedef struct packed {
        logic               found;
        logic [START_W-1:0] start_idx;
        logic [END_W-1:0]   end_idx;
    } span_t;

    // One directed line: optional register settings, a line made of a
    // block of hit voxels (hit_a..hit_b) on a background, and an optional
    // expected span typed in by hand.
    typedef struct packed {
        logic        wr;
        logic        poke;
        logic [8:0]  thr;
        logic [8:0]  mrun;
        logic [8:0]  dil;
        logic [9:0]  len;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [9:0]  hit_a;
        logic [9:0]  hit_b;
        logic        typed;
        span_t       want;
    } line_case_t;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = REG_HIT_THRESHOLD;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata   = '0;   // [7:0] voxel
    logic                   s_tlast   = 1'b0; // last_in_line
    logic                   m_tvalid;
    logic                   m_tready  = 1'b1;
    logic [M_DATA_W-1:0]    m_tdata;          // [8:0] span_start, [16:9] span_end
    logic                   m_tuser;          // span_found

    line_run_span_finder_top #(
        .LINE_MAX (LINE_MAX)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Span predictor: its own copy of the registers and of the line state.
    // ------------------------------------------------------------------------
    logic [THRESH_W-1:0] thr_q     = THRESH_RESET;
    logic [RUN_W-1:0]    min_run_q = MIN_RUN_RESET;
    logic [DIL_W-1:0]    dil_q     = DIL_RESET;

    bit hit_bits [LINE_MAX];
    int stored_len = 0;
    int fwd_run    = 0;
    int fwd_edge   = 0;
    bit fwd_done   = 1'b0;

    span_t span_q [$];      // spans still owed by the block, oldest first
    int    error_count = 0;

    // Directed rows with a typed span hand it over through these.
    bit    use_typed = 1'b0;
    span_t typed_span;

    // Calm lines run with no idling on either stream.
    bit calm = 1'b0;

    // Span of the line just closed, from the stored hits and the forward scan.
    function automatic span_t close_line();
        span_t       sp;
        int          s;
        int          c;
        int          e;
        int unsigned run;
        bit          ok;
        sp  = '0;
        ok  = fwd_done;
        s   = fwd_edge;
        run = 0;
        // A zero run length is met at once, right at the line start.
        if (min_run_q == 0)
        begin
            ok = 1'b1;
            s  = 0;
        end
        if (ok)
        begin
            // Walk back from the last stored voxel, never down to start.
            c = stored_len - 1;
            while (c > s && run < min_run_q)
            begin
                if (c >= 0 && c < LINE_MAX && hit_bits[c])
                    run++;
                else
                    run = 0;
                c--;
            end
            e = c;
            s = (s >= int'(dil_q)) ? s - int'(dil_q) : 0;
            e = (e + int'(dil_q) <= stored_len - 1) ? e + int'(dil_q) : stored_len - 1;
            sp.found     = 1'b1;
            sp.start_idx = s[START_W-1:0];
            sp.end_idx   = e[END_W-1:0];
        end
        return sp;
    endfunction

    // One accepted voxel beat; the closing beat queues the line's span.
    function automatic void take_voxel(logic [VOXEL_W-1:0] v, logic closes);
        bit hit;
        hit = (v > thr_q);
        // Voxels past the hit store are dropped, but the flag still closes.
        if (stored_len < LINE_MAX)
        begin
            hit_bits[stored_len] = hit;
            if (!fwd_done && min_run_q != 0)
            begin
                fwd_run = hit ? fwd_run + 1 : 0;
                if (fwd_run >= min_run_q)
                begin
                    fwd_done = 1'b1;
                    fwd_edge = stored_len + 1;
                end
            end
            stored_len++;
        end
        if (closes)
        begin
            span_q.push_back(use_typed ? typed_span : close_line());
            stored_len = 0;
            fwd_run    = 0;
            fwd_edge   = 0;
            fwd_done   = 1'b0;
        end
    endfunction

    // Register writes land at the same edge the block takes them.
    always @(posedge clk)
    begin
        if (rst_n && cfg_we)
        begin
            case (cfg_index)
                REG_HIT_THRESHOLD: thr_q     = cfg_data[THRESH_W-1:0];
                REG_MIN_RUN:       min_run_q = cfg_data[RUN_W-1:0];
                REG_DILATION:      dil_q     = cfg_data[DIL_W-1:0];
                default:           ;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            take_voxel(s_tdata[VOXEL_W-1:0], s_tlast);
    end

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t ns: %s got %h want %h", $time, what, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin : span_check
        span_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (span_q.size() == 0)
                report_mismatch("span beat with none pending", 32'({m_tuser, m_tdata}), '0);
            else
            begin
                want = span_q.pop_front();
                if (m_tuser !== want.found)
                    report_mismatch("span_found", 32'(m_tuser), 32'(want.found));
                if (m_tdata[START_W-1:0] !== want.start_idx)
                    report_mismatch("span_start", 32'(m_tdata[START_W-1:0]),
                                    32'(want.start_idx));
                if (m_tdata[START_W+END_W-1:START_W] !== want.end_idx)
                    report_mismatch("span_end", 32'(m_tdata[START_W+END_W-1:START_W]),
                                    32'(want.end_idx));
                if (m_tdata[M_DATA_W-1:START_W+END_W] !== '0)
                    report_mismatch("tdata padding",
                                    32'(m_tdata[M_DATA_W-1:START_W+END_W]), '0);
            end
        end
    end

    // Hard stop if the block hangs or loses a span.
    int cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Pacing: mostly no gap, often a short one, now and then a long one.
    // ------------------------------------------------------------------------
    function automatic int idle_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(99, 0);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // The result side stalls on the same kind of schedule.
    int ready_hold = 0;
    always @(negedge clk)
    begin : sink_pace
        int g;
        if (ready_hold > 0)
        begin
            ready_hold--;
            m_tready <= 1'b0;
        end
        else
        begin
            g = idle_gap();
            ready_hold = (g > 0) ? g - 1 : 0;
            m_tready <= (g == 0);
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat
    // was taken, leaving tvalid high so back-to-back beats need no toggle.
    task automatic send_beat(input logic [7:0] v, input logic closes);
        int g;
        g = idle_gap();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= closes;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Stop the voxel stream and let every owed span come back.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (span_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write the registers picked by mask, then the unused index if asked.
    task automatic set_regs(input logic [2:0] mask, input logic [8:0] thr,
                            input logic [8:0] mrun, input logic [8:0] dil,
                            input bit poke);
        if (mask[0])
        begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_HIT_THRESHOLD;
            cfg_data  <= thr;
            @(negedge clk);
        end
        if (mask[1])
        begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_MIN_RUN;
            cfg_data  <= mrun;
            @(negedge clk);
        end
        if (mask[2])
        begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_DILATION;
            cfg_data  <= dil;
            @(negedge clk);
        end
        if (poke)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_UNUSED;
            cfg_data  <= 9'h1FF;
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Voxel values on either side of the current threshold. With a
    // threshold of 255 nothing can hit, so the top value is used.
    function automatic logic [7:0] hit_val();
        if (thr_q == 8'hFF)
            return 8'hFF;
        return 8'($urandom_range(255, int'(thr_q) + 1));
    endfunction

    function automatic logic [7:0] miss_val();
        return 8'($urandom_range(int'(thr_q), 0));
    endfunction

    // ------------------------------------------------------------------------
    // Directed lines. The first row runs on the reset register values; the
    // second also writes the unused index, which must leave the defaults.
    // ------------------------------------------------------------------------
    line_case_t line_cases [16] = '{
        //  wr poke thr  mrun  dil  len  lo   hi   a    b   typed want
        '{1'b0, 1'b0,  9'd20,   9'd2,   9'd0,   10'd1,   8'd0,   8'd0,
          10'd1,   10'd0,   1'b1, '{1'b0, 9'd0,   8'd0}},
        '{1'b1, 1'b1,  9'd20,   9'd2,   9'd0,   10'd8,   8'd0,   8'd21,
          10'd0,   10'd7,   1'b1, '{1'b1, 9'd2,   8'd5}},
        // Threshold data wider than the register keeps only its low byte.
        '{1'b1, 1'b0,  9'h1FF,  9'd2,   9'd0,   10'd6,   8'd255, 8'd255,
          10'd0,   10'd5,   1'b1, '{1'b0, 9'd0,   8'd0}},
        '{1'b1, 1'b0,  9'd0,    9'd1,   9'd0,   10'd4,   8'd0,   8'd1,
          10'd0,   10'd3,   1'b1, '{1'b1, 9'd1,   8'd2}},
        // Zero run length: span covers the whole line.
        '{1'b1, 1'b0,  9'd20,   9'd0,   9'd0,   10'd5,   8'd0,   8'd0,
          10'd1,   10'd0,   1'b1, '{1'b1, 9'd0,   8'd4}},
        // Full line of hits with the longest run: start lands past the end.
        '{1'b1, 1'b0,  9'd20,   9'd256, 9'd0,   10'd256, 8'd0,   8'd255,
          10'd0,   10'd255, 1'b1, '{1'b1, 9'd256, 8'd255}},
        // Longer than the hit store: the tail is dropped.
        '{1'b1, 1'b0,  9'd20,   9'd2,   9'd0,   10'd300, 8'd0,   8'd255,
          10'd0,   10'd299, 1'b1, '{1'b1, 9'd2,   8'd253}},
        // Wide dilation clamps both ends to the line.
        '{1'b1, 1'b0,  9'd20,   9'd2,   9'd256, 10'd8,   8'd0,   8'd255,
          10'd0,   10'd7,   1'b1, '{1'b1, 9'd0,   8'd7}},
        // Run closing at the line end: empty span.
        '{1'b1, 1'b0,  9'd20,   9'd2,   9'd0,   10'd10,  8'd0,   8'd255,
          10'd8,   10'd9,   1'b1, '{1'b1, 9'd10,  8'd9}},
        '{1'b1, 1'b0,  9'd100,  9'd3,   9'd2,   10'd20,  8'd100, 8'd101,
          10'd5,   10'd12,  1'b0, '0},
        '{1'b1, 1'b0,  9'd200,  9'd4,   9'd511, 10'd30,  8'd7,   8'd254,
          10'd3,   10'd20,  1'b0, '0},
        '{1'b1, 1'b0,  9'd50,   9'd1,   9'd1,   10'd1,   8'd0,   8'd51,
          10'd0,   10'd0,   1'b0, '0},
        '{1'b1, 1'b0,  9'd128,  9'd5,   9'd3,   10'd64,  8'd0,   8'd129,
          10'd10,  10'd13,  1'b0, '0},
        // A run length no line can reach.
        '{1'b1, 1'b0,  9'd20,   9'd511, 9'd0,   10'd40,  8'd0,   8'd255,
          10'd0,   10'd39,  1'b1, '{1'b0, 9'd0,   8'd0}},
        // Hits only past the hit store never count.
        '{1'b1, 1'b0,  9'd20,   9'd2,   9'd0,   10'd280, 8'd0,   8'd255,
          10'd260, 10'd279, 1'b1, '{1'b0, 9'd0,   8'd0}},
        '{1'b1, 1'b0,  9'd20,   9'd3,   9'd4,   10'd12,  8'd0,   8'd255,
          10'd9,   10'd11,  1'b0, '0}
    };

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        logic [7:0] line_vox [];
        logic [8:0] thr;
        logic [8:0] mrun;
        logic [8:0] dil;
        int beats;
        int len;
        int shape;
        int r;
        int a;
        int b;
        int a2;
        int b2;
        bit in_run;
        bit all_hit;

        beats = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (line_cases[i])
        begin
            wait_idle();
            if (line_cases[i].wr)
                set_regs(3'b111, line_cases[i].thr, line_cases[i].mrun,
                         line_cases[i].dil, line_cases[i].poke);
            use_typed  = line_cases[i].typed;
            typed_span = line_cases[i].want;
            for (int k = 0; k < int'(line_cases[i].len); k++)
                send_beat((k >= int'(line_cases[i].hit_a) && k <= int'(line_cases[i].hit_b))
                          ? line_cases[i].hi : line_cases[i].lo,
                          k == int'(line_cases[i].len) - 1);
            use_typed = 1'b0;
            beats += int'(line_cases[i].len);
        end

        // Random lines: mostly one or two blocks of hits on a quiet
        // background, some with noise, a few of pure noise.
        while (beats < TOTAL_BEATS)
        begin
            calm = ($urandom_range(7, 0) == 0);

            if ($urandom_range(3, 0) == 0)
            begin
                case ($urandom_range(9, 0))
                    0:       thr = 9'd0;
                    1:       thr = 9'd255;
                    2:       thr = {1'b1, 8'($urandom_range(255, 0))};
                    default: thr = 9'($urandom_range(200, 5));
                endcase
                case ($urandom_range(19, 0))
                    0:       mrun = 9'd0;
                    1:       mrun = 9'd256;
                    2:       mrun = 9'($urandom_range(511, 257));
                    3, 4:    mrun = 9'd1;
                    default: mrun = 9'($urandom_range(8, 2));
                endcase
                case ($urandom_range(9, 0))
                    0, 1, 2, 3: dil = 9'd0;
                    4:          dil = 9'd256;
                    5:          dil = 9'd511;
                    default:    dil = 9'($urandom_range(10, 1));
                endcase
                wait_idle();
                set_regs(3'($urandom_range(7, 1)), thr, mrun, dil,
                         $urandom_range(15, 0) == 0);
            end

            r = $urandom_range(99, 0);
            if (r < 85)
                len = $urandom_range(24, 1);
            else if (r < 97)
                len = $urandom_range(LINE_MAX, 25);
            else
                len = $urandom_range(LINE_MAX + 44, LINE_MAX + 1);

            shape   = $urandom_range(9, 0);
            a       = $urandom_range(len - 1, 0);
            b       = $urandom_range(len - 1, a);
            a2      = $urandom_range(len - 1, 0);
            b2      = $urandom_range(len - 1, a2);
            all_hit = 1'($urandom_range(1, 0));
            line_vox = new[len];
            foreach (line_vox[k])
            begin
                in_run = (k >= a && k <= b) || (shape == 7 && k >= a2 && k <= b2);
                if ((shape == 5 || shape == 6) && $urandom_range(7, 0) == 0)
                    in_run = !in_run;
                if (shape == 9)
                    in_run = all_hit;
                if (shape == 8)
                    line_vox[k] = 8'($urandom_range(255, 0));
                else
                    line_vox[k] = in_run ? hit_val() : miss_val();
            end

            foreach (line_vox[k])
                send_beat(line_vox[k], k == len - 1);
            beats += len;
        end

        s_tvalid <= 1'b0;
        calm = 1'b0;
        while (span_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> line_run_span_finder_top.f
hdl/lrsf_pkg.sv
hdl/lrsf_ram.sv
hdl/line_run_span_finder_top.sv
sim/tb.sv
